// File: src/fqri_pkg.sv
// shared types and constants for the fastq record indexer
// no dependencies; imported by every module of the block

package fqri_pkg;

    localparam int OFFSET_BITS_DEF = 32;
    localparam int LENGTH_BITS_DEF = 16;

    // record queue between parser and output stage
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_AT    = 8'd64;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_SEQUENCE  = 3'd1,
        PH_SEPARATOR = 3'd2,
        PH_QUALITY   = 3'd3,
        PH_GAP       = 3'd4
    } phase_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: src/fqri_front.sv
// front end: takes file bytes, tracks the record phase and builds index records
// depends on fqri_pkg; feeds fqri_queue

module fqri_front #(
    parameter int OFFSET_BITS = 32,
    parameter int LENGTH_BITS = 16,
    parameter int REC_BITS    = 2 * OFFSET_BITS + 2 * LENGTH_BITS + 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_valid,
    output logic                    byte_ready,
    input  logic [7:0]              byte_data,
    input  fqri_pkg::queue_status_t status,
    output logic                    push,
    output logic [REC_BITS-1:0]     rec
);
    import fqri_pkg::*;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    phase_t                 phase_reg, phase_next;
    logic [7:0]             prev_reg;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] seq_start_reg, seq_start_next;
    logic [LENGTH_BITS-1:0] seq_count_reg, seq_count_next;
    logic [OFFSET_BITS-1:0] qual_start_reg, qual_start_next;
    logic [LENGTH_BITS-1:0] qual_count_reg, qual_count_next;
    logic                   accept;
    logic                   blank;
    logic                   emit;

    assign byte_ready = !status.full;
    assign accept     = byte_valid && byte_ready;
    assign pos_next   = pos_reg + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
    assign blank      = (byte_data == CH_SPACE) || (byte_data == CH_TAB)
                      || (byte_data == CH_NL);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SEQUENCE:
            begin
                if (!blank && prev_reg == CH_NL && byte_data == CH_PLUS)
                    phase_next = PH_SEPARATOR;
            end
            PH_SEPARATOR:
            begin
                if (byte_data == CH_NL)
                    phase_next = PH_QUALITY;
            end
            PH_QUALITY:
            begin
                if (byte_data == CH_NL)
                    phase_next = PH_GAP;
            end
            PH_GAP:
            begin
                if (prev_reg == CH_NL && byte_data == CH_AT)
                    phase_next = PH_HEADER;
            end
            default:
            begin
                // header, and any code that cannot arise
                if (byte_data == CH_NL)
                    phase_next = PH_SEQUENCE;
                else
                    phase_next = PH_HEADER;
            end
        endcase
    end

    // counters, offsets and record emission
    always_comb
    begin
        seq_start_next  = seq_start_reg;
        seq_count_next  = seq_count_reg;
        qual_start_next = qual_start_reg;
        qual_count_next = qual_count_reg;
        emit            = 1'b0;
        unique case (phase_reg)
            PH_SEQUENCE:
            begin
                if (!blank && !(prev_reg == CH_NL && byte_data == CH_PLUS)
                    && seq_count_reg != LEN_MAX)
                    seq_count_next = seq_count_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            end
            PH_SEPARATOR:
            begin
                if (byte_data == CH_NL)
                begin
                    qual_start_next = pos_next;
                    qual_count_next = '0;
                end
            end
            PH_QUALITY:
            begin
                if (byte_data == CH_NL)
                    emit = 1'b1;
                else if (qual_count_reg != LEN_MAX)
                    qual_count_next = qual_count_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
            end
            PH_GAP:
            begin
            end
            default:
            begin
                if (byte_data == CH_NL)
                begin
                    seq_start_next = pos_next;
                    seq_count_next = '0;
                end
            end
        endcase
    end

    assign push = accept && emit;
    assign rec  = {(seq_count_reg != qual_count_reg), qual_count_reg, qual_start_reg,
                   seq_count_reg, seq_start_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            prev_reg       <= CH_NL;
            pos_reg        <= '0;
            seq_start_reg  <= '0;
            seq_count_reg  <= '0;
            qual_start_reg <= '0;
            qual_count_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            prev_reg       <= byte_data;
            pos_reg        <= pos_next;
            seq_start_reg  <= seq_start_next;
            seq_count_reg  <= seq_count_next;
            qual_start_reg <= qual_start_next;
            qual_count_reg <= qual_count_next;
        end
    end

endmodule

// File: src/fqri_queue.sv
// short record queue between the parser and the output stage
// depends on fqri_pkg for depth and status type

module fqri_queue #(
    parameter int WIDTH = 97
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [WIDTH-1:0]        push_data,
    input  logic                    pop,
    output logic [WIDTH-1:0]        head_data,
    output fqri_pkg::queue_status_t status
);
    import fqri_pkg::*;

    logic [WIDTH-1:0]          mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + {{QUEUE_PTR_BITS{1'b0}}, 1'b1};
        else if (pop && !push)
            count_next = count_reg - {{QUEUE_PTR_BITS{1'b0}}, 1'b1};
    end

    assign status    = '{full:  (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH)),
                         empty: (count_reg == '0)};
    assign head_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + {{(QUEUE_PTR_BITS-1){1'b0}}, 1'b1};
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + {{(QUEUE_PTR_BITS-1){1'b0}}, 1'b1};
            count_reg <= count_next;
        end
    end

endmodule

// File: src/fqri_back.sv
// back end: output register that drains the record queue onto the master side
// depends on fqri_pkg for the queue status type

module fqri_back #(
    parameter int REC_BITS   = 97,
    parameter int TDATA_BITS = 104
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fqri_pkg::queue_status_t status,
    input  logic [REC_BITS-1:0]     head_data,
    output logic                    pop,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [TDATA_BITS-1:0]   m_axis_tdata
);
    import fqri_pkg::*;

    logic                valid_reg;
    logic [REC_BITS-1:0] data_reg;

    // reload whenever the register is empty or its transfer completes
    assign pop           = !status.empty && (!valid_reg || m_axis_tready);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(TDATA_BITS-REC_BITS){1'b0}}, data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || m_axis_tready)
            valid_reg <= !status.empty;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head_data;
    end

endmodule

// File: src/fastq_record_indexer_unit.sv
// record path: a record enters the record queue on the transfer of the newline
// that ends its quality line; throughput: one byte per cycle while the queue is
// not full; parser state updates per accepted byte and a four-entry record
// queue plus output register decouple the two sides
// reset: rst_n asynchronous active low; parser returns to header phase with
// offset zero, queue and output register empty
// depends on fqri_pkg, fqri_front, fqri_queue, fqri_back

module fastq_record_indexer_unit #(
    parameter int OFFSET_BITS = fqri_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = fqri_pkg::LENGTH_BITS_DEF,
    localparam int REC_BITS   = 2 * OFFSET_BITS + 2 * LENGTH_BITS + 1,
    localparam int TDATA_BITS = ((REC_BITS + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // byte_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // seq_offset, seq_length, qual_offset, qual_length, length_mismatch, zero fill
    output logic [TDATA_BITS-1:0] m_axis_tdata
);
    import fqri_pkg::*;

    queue_status_t       status;
    logic                push;
    logic                pop;
    logic [REC_BITS-1:0] rec;
    logic [REC_BITS-1:0] head_data;

    fqri_front #(
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .REC_BITS    (REC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_axis_tvalid),
        .byte_ready (s_axis_tready),
        .byte_data  (s_axis_tdata),
        .status     (status),
        .push       (push),
        .rec        (rec)
    );

    fqri_queue #(
        .WIDTH (REC_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (rec),
        .pop       (pop),
        .head_data (head_data),
        .status    (status)
    );

    fqri_back #(
        .REC_BITS   (REC_BITS),
        .TDATA_BITS (TDATA_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .status        (status),
        .head_data     (head_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: src/fqri_checker.sv
// port-level checks for the fastq record indexer, bound to the top level
// depends on fqri_pkg and fastq_record_indexer_unit

module fqri_checker #(
    parameter int TDATA_BITS = 104
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [7:0]            s_axis_tdata,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [TDATA_BITS-1:0] m_axis_tdata
);
    import fqri_pkg::*;

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a fresh result follows an accepted newline transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |->
            $past(s_axis_tvalid && s_axis_tready && s_axis_tdata == CH_NL, 2))
        else $error("result without a terminating newline");

    // input back-pressure only when results are held up
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind fastq_record_indexer_unit fqri_checker #(.TDATA_BITS(TDATA_BITS)) u_checker (.*);

// File: sim/fastq_record_indexer_unit_test.sv
// self-checking testbench for fastq_record_indexer_unit: feeds FASTQ byte streams,
// predicts every index record and compares it with m_axis field by field
// depends on fqri_pkg and the fastq_record_indexer_unit rtl

module fastq_record_indexer_unit_test;

    import fqri_pkg::*;

    localparam int OFFSET_W   = fqri_pkg::OFFSET_BITS_DEF;
    localparam int LENGTH_W   = fqri_pkg::LENGTH_BITS_DEF;
    localparam int RECORD_W   = 2 * OFFSET_W + 2 * LENGTH_W + 1;
    localparam int TDATA_W    = ((RECORD_W + 7) / 8) * 8;

    localparam int SEQ_OFF_LSB  = 0;
    localparam int SEQ_LEN_LSB  = SEQ_OFF_LSB + OFFSET_W;
    localparam int QUAL_OFF_LSB = SEQ_LEN_LSB + LENGTH_W;
    localparam int QUAL_LEN_LSB = QUAL_OFF_LSB + OFFSET_W;
    localparam int MISMATCH_BIT = QUAL_LEN_LSB + LENGTH_W;

    localparam int RANDOM_BYTES   = 1100;
    localparam int RANDOM_RECORDS = 32;
    localparam int TAIL_CYCLES    = 10;
    localparam int CYCLE_LIMIT    = 200000;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_HOLD
    } ready_mode_t;

    typedef struct {
        bit [OFFSET_W-1:0] seq_offset;
        bit [LENGTH_W-1:0] seq_length;
        bit [OFFSET_W-1:0] qual_offset;
        bit [LENGTH_W-1:0] qual_length;
        bit                length_mismatch;
    } index_record_t;

    class fastq_index_tracker;
        phase_t            phase;
        bit [7:0]          last_byte;
        bit [OFFSET_W-1:0] position;
        bit [OFFSET_W-1:0] seq_start;
        bit [OFFSET_W-1:0] qual_start;
        bit [LENGTH_W-1:0] seq_count;
        bit [LENGTH_W-1:0] qual_count;
        index_record_t     pending_records[$];
        int                errors;
        int                records_predicted;

        function new();
            phase             = PH_HEADER;
            last_byte         = CH_NL;
            position          = '0;
            seq_start         = '0;
            qual_start        = '0;
            seq_count         = '0;
            qual_count        = '0;
            errors            = 0;
            records_predicted = 0;
        endfunction

        function int pending();
            return pending_records.size();
        endfunction

        // advance the parser by one accepted byte
        function void take_byte(bit [7:0] b);
            bit [OFFSET_W-1:0] next_pos;
            index_record_t     rec;
            next_pos = position + 1'b1;
            case (phase)
                PH_SEQUENCE:
                begin
                    if (b != CH_SPACE && b != CH_TAB && b != CH_NL)
                    begin
                        if (last_byte == CH_NL && b == CH_PLUS)
                            phase = PH_SEPARATOR;
                        else if (seq_count != '1)
                            seq_count = seq_count + 1'b1;
                    end
                end
                PH_SEPARATOR:
                begin
                    if (b == CH_NL)
                    begin
                        phase      = PH_QUALITY;
                        qual_start = next_pos;
                        qual_count = '0;
                    end
                end
                PH_QUALITY:
                begin
                    if (b == CH_NL)
                    begin
                        rec.seq_offset      = seq_start;
                        rec.seq_length      = seq_count;
                        rec.qual_offset     = qual_start;
                        rec.qual_length     = qual_count;
                        rec.length_mismatch = (seq_count != qual_count);
                        pending_records.push_back(rec);
                        records_predicted++;
                        phase = PH_GAP;
                    end
                    else if (qual_count != '1)
                    begin
                        qual_count = qual_count + 1'b1;
                    end
                end
                PH_GAP:
                begin
                    if (last_byte == CH_NL && b == CH_AT)
                        phase = PH_HEADER;
                end
                default:
                begin
                    if (b == CH_NL)
                    begin
                        phase     = PH_SEQUENCE;
                        seq_start = next_pos;
                        seq_count = '0;
                    end
                end
            endcase
            last_byte = b;
            position  = next_pos;
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_record(logic [TDATA_W-1:0] tdata);
            index_record_t want;
            if (pending_records.size() == 0)
            begin
                $display("%0t: record with nothing expected, expected none actual %h",
                         $time, tdata);
                errors++;
                return;
            end
            want = pending_records.pop_front();
            check_field("seq_offset", 64'(want.seq_offset),
                        64'(tdata[SEQ_OFF_LSB +: OFFSET_W]));
            check_field("seq_length", 64'(want.seq_length),
                        64'(tdata[SEQ_LEN_LSB +: LENGTH_W]));
            check_field("qual_offset", 64'(want.qual_offset),
                        64'(tdata[QUAL_OFF_LSB +: OFFSET_W]));
            check_field("qual_length", 64'(want.qual_length),
                        64'(tdata[QUAL_LEN_LSB +: LENGTH_W]));
            check_field("length_mismatch", 64'(want.length_mismatch),
                        64'(tdata[MISMATCH_BIT]));
        endfunction
    endclass

    // headerless first record with blanks, a mid-line plus and extreme byte values,
    // a stray at-sign in the gap, then an empty sequence with an empty quality line
    localparam bit [7:0] DIRECTED [24] = '{
        8'hFF, 8'h00, CH_NL,
        "A", CH_SPACE, CH_PLUS, CH_TAB, "C", 8'h01, CH_NL,
        CH_PLUS, CH_NL,
        "!", "~", 8'hFF, CH_NL,
        "x", CH_AT, CH_NL,
        CH_AT, CH_NL, CH_PLUS, CH_NL, CH_NL
    };

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata  = '0;     // byte_in
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // seq_offset, seq_length, qual_offset, qual_length, length_mismatch, zero fill
    logic [TDATA_W-1:0] m_axis_tdata;

    fastq_index_tracker tracker;
    int                 cycle_count = 0;
    int                 bytes_sent  = 0;
    int                 burst_left  = 0;
    ready_mode_t        ready_mode  = READY_ALWAYS;
    int                 ready_left  = 0;

    fastq_record_indexer_unit #(
        .OFFSET_BITS(OFFSET_W),
        .LENGTH_BITS(LENGTH_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("fastq_record_indexer_unit_test NOT OK");
            $finish;
        end
    end

    // sample both sides on the edge at which the transfer happens
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            tracker.take_byte(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.match_record(m_axis_tdata);
    end

    // receiver back-pressure in runs of differing behaviour
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_left = (ready_mode == READY_HOLD) ? $urandom_range(1, 10)
                                                    : $urandom_range(1, 60);
        end
        ready_left = ready_left - 1;
        case (ready_mode)
            READY_ALWAYS: m_axis_tready <= 1'b1;
            READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: m_axis_tready <= (ready_left % 4 == 0);
            default:      m_axis_tready <= 1'b0;
        endcase
    end

    task automatic send_byte(input bit [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left = burst_left - 1;
        bytes_sent = bytes_sent + 1;
    endtask

    // hold the sender until every predicted record has left the block
    task automatic drain_records();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    function automatic bit [7:0] random_text_byte();
        bit [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_NL);
        return b;
    endfunction

    function automatic bit [7:0] random_seq_byte();
        bit [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_NL || b == CH_TAB || b == CH_SPACE || b == CH_PLUS);
        return b;
    endfunction

    function automatic bit [7:0] nucleotide();
        string bases;
        bases = "ACGTN";
        return bases[$urandom_range(0, 4)];
    endfunction

    // one record; messy ones carry blanks, wrapped lines and odd bytes
    task automatic send_record(input int seq_len, input int qual_len, input bit messy);
        send_byte(CH_AT);
        repeat ($urandom_range(0, 8)) send_byte(random_text_byte());
        send_byte(CH_NL);
        for (int i = 0; i < seq_len; i++)
        begin
            if (messy && $urandom_range(0, 5) == 0)
                send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            if (messy && i > 0 && $urandom_range(0, 9) == 0)
                send_byte(CH_NL);
            if (messy && $urandom_range(0, 3) == 0)
                send_byte(random_seq_byte());
            else
                send_byte(nucleotide());
        end
        send_byte(CH_NL);
        send_byte(CH_PLUS);
        if (messy)
            repeat ($urandom_range(0, 5)) send_byte(random_text_byte());
        send_byte(CH_NL);
        for (int i = 0; i < qual_len; i++)
            send_byte(messy ? random_text_byte() : 8'($urandom_range(33, 126)));
        send_byte(CH_NL);
    endtask

    initial
    begin : stimulus
        int kind;
        int seq_len;
        int start_bytes;
        int start_records;
        bit paused_mid;
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i]);
        drain_records();

        start_bytes   = bytes_sent;
        start_records = tracker.records_predicted;
        paused_mid    = 1'b0;
        while (bytes_sent - start_bytes < RANDOM_BYTES ||
               tracker.records_predicted - start_records < RANDOM_RECORDS)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                seq_len = $urandom_range(0, 20);
                send_record(seq_len,
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : seq_len,
                            1'($urandom_range(0, 1)));
            end
            else if (kind == 7)
            begin
                repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
            end
            else if (kind == 8)
            begin
                // record cut short before its separator
                send_byte(CH_AT);
                send_byte(CH_NL);
                repeat ($urandom_range(0, 6)) send_byte(nucleotide());
                send_byte(CH_NL);
            end
            else
            begin
                repeat ($urandom_range(0, 10)) send_byte(random_text_byte());
                send_byte(CH_NL);
            end
            if (!paused_mid && bytes_sent - start_bytes >= RANDOM_BYTES / 2)
            begin
                drain_records();
                paused_mid = 1'b1;
            end
        end

        drain_records();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("fastq_record_indexer_unit_test OK");
        else
            $display("fastq_record_indexer_unit_test NOT OK");
        $finish;
    end

endmodule
